FILE: src/assert_macros.svh
// Assertion macros shared by the scan driver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/sssd_pkg.sv
// Shared types, tables and arithmetic helpers for the seven-segment scan driver.
`timescale 1ns / 1ps

package sssd_pkg;

	// Widest digit index plus one (up to eight digits, plus the next higher weight).
	localparam int unsigned IdxW = 4;
	localparam int unsigned ValueW = 14;
	localparam int unsigned SegW = 7;
	localparam int unsigned DigitPosW = 2;

	typedef logic [ValueW-1:0] value_t;
	typedef logic [SegW-1:0] seg_t;
	typedef logic [IdxW-1:0] idx_t;

	// Result of decoding one digit: whether it lights and its segment pattern.
	typedef struct packed {
		logic lit;
		seg_t segments;
	} digit_dec_t;

	// Power of ten, evaluated at elaboration for the range limit.
	function automatic int pow10(input int n);
		int r;
		int i;
		r = 1;
		for (i = 0; i < n && i < 9; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	// Quotient of a 14-bit value by 10^k, by reciprocal multiplication.
	// The reciprocals are exact over the whole 14-bit range.
	function automatic value_t div_pow10(input value_t x, input idx_t k);
		logic [31:0] p;
		value_t q;
		p = '0;
		q = '0;
		unique case (k)
			4'd0: q = x;
			4'd1: begin
				p = 32'(x) * 32'd52429;
				q = ValueW'(p >> 19);
			end
			4'd2: begin
				p = 32'(x) * 32'd5243;
				q = ValueW'(p >> 19);
			end
			4'd3: begin
				p = 32'(x) * 32'd16778;
				q = ValueW'(p >> 24);
			end
			4'd4: begin
				p = 32'(x) * 32'd13422;
				q = ValueW'(p >> 27);
			end
			default: q = '0;
		endcase
		return q;
	endfunction

	// Segment pattern of a decimal digit; bit0 top through bit6 middle.
	function automatic seg_t seg_of(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: src/sssd_digit.sv
// Decimal digit extraction and segment decode for one scan position.
`timescale 1ns / 1ps

module sssd_digit #(
	parameter int DIGIT_COUNT = 4
) (
	input  sssd_pkg::value_t     value,
	input  logic                 out_of_range,
	input  sssd_pkg::idx_t       digit_idx,
	output sssd_pkg::digit_dec_t dec
);

	localparam int ValueLimit = sssd_pkg::pow10(DIGIT_COUNT) - 1;

	sssd_pkg::value_t q_cur;
	sssd_pkg::value_t q_next;
	sssd_pkg::value_t q_next_x10;
	sssd_pkg::value_t digit_full;
	logic             in_range;

	// The digit at weight 10^k is floor(v / 10^k) - 10 * floor(v / 10^(k+1)).
	always_comb begin
		q_cur      = sssd_pkg::div_pow10(value, digit_idx);
		q_next     = sssd_pkg::div_pow10(value, digit_idx + 1'b1);
		q_next_x10 = (q_next << 3) + (q_next << 1);
		digit_full = q_cur - q_next_x10;
		in_range   = 32'(value) <= 32'(ValueLimit);
		dec.lit    = !out_of_range && in_range && ((digit_idx == '0) || (q_cur != '0));
		dec.segments = dec.lit ? sssd_pkg::seg_of(digit_full[3:0]) : '0;
	end

endmodule

FILE: src/seven_segment_scan_driver_core.sv
// Top level of the seven-segment scan driver: scan counter, pipeline and stream ports.
`timescale 1ns / 1ps
// Usage
// Each input item is one refresh tick. s_tdata[13:0] carries the value to show and
// s_tuser[0] flags it as out of range. For every item the block returns one result
// item on the master side: m_tdata[1:0] is the enabled digit position (0 is the
// leftmost digit) and m_tdata[8:2] the segment pattern, bit 0 top through bit 6 middle.
// A scan counter steps from DIGIT_COUNT-1 down to 0 and wraps, one step per item.
// The value is shown right aligned in decimal with leading digits blank; values too
// large for the display, or flagged, blank every segment. On a blank tick the digit
// position repeats the last position that was lit.
// The result is presented from the result register: the item passes one input register
// stage, then the result register, and a receiver stall can hold it in either stage.
// Throughput is one item per cycle while the receiver does not stall, set by the
// single-pass decode between those two registers.
// Reset puts the scan counter at DIGIT_COUNT-1, the held digit position at 0, and
// empties both stages. When the receiver stalls, the result register holds its item
// and the input stage keeps one more; s_tready drops only when both are full.

`include "assert_macros.svh"

module seven_segment_scan_driver_core #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] value_cm, [15:14] zero
	input  logic [0:0]  s_tuser,   // [0] out_of_range
	// Result item stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] digit_position, [8:2] segments, [15:9] zero
);

	localparam int PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// Scan counter, advanced once per accepted item.
	logic [PosW-1:0] scan_q;

	// Input register stage.
	logic             valid_s1;
	sssd_pkg::value_t value_s1;
	logic             flag_s1;
	logic [PosW-1:0]  pos_s1;

	// Result register and the held digit position.
	logic                                 out_valid_q;
	sssd_pkg::seg_t                       seg_q;
	logic [sssd_pkg::DigitPosW-1:0]       enabled_q;

	logic                 in_fire;
	logic                 advance;
	logic                 load_out;
	sssd_pkg::idx_t       digit_idx;
	sssd_pkg::digit_dec_t dec;

	// The result register frees when empty or when its item is taken; the input stage
	// frees when empty or when it moves into the result register.
	assign advance  = !out_valid_q || m_tready;
	assign load_out = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= PosW'(DIGIT_COUNT - 1);
		end else if (in_fire) begin
			if (scan_q == '0) begin
				scan_q <= PosW'(DIGIT_COUNT - 1);
			end else begin
				scan_q <= scan_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// The item payload travels with its scan position.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_s1 <= s_tdata[13:0];
			flag_s1  <= s_tuser[0];
			pos_s1   <= scan_q;
		end
	end

	// Weight index: position DIGIT_COUNT-1 is the units digit.
	assign digit_idx = sssd_pkg::IdxW'(DIGIT_COUNT - 1) - sssd_pkg::IdxW'(pos_s1);

	sssd_digit #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_digit (
		.value        (value_s1),
		.out_of_range (flag_s1),
		.digit_idx    (digit_idx),
		.dec          (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			enabled_q   <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			// A lit digit moves the enabled position; a blank one leaves it.
			if (load_out && dec.lit) begin
				enabled_q <= sssd_pkg::DigitPosW'(pos_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			seg_q <= dec.segments;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, seg_q, enabled_q};

	`ASSERT_NEXT(a_scan_wrap, in_fire && (scan_q == '0), scan_q == PosW'(DIGIT_COUNT - 1),
		"scan counter did not wrap to the last position")
	`ASSERT_NEXT(a_scan_step, in_fire && (scan_q != '0), scan_q == $past(scan_q) - 1'b1,
		"scan counter did not step down by one")
	`ASSERT_NEXT(a_out_load, load_out, out_valid_q,
		"result register did not take the item from the input stage")
	`ASSERT_NEXT(a_pos_hold, !(load_out && dec.lit), $stable(enabled_q),
		"digit position changed without a lit digit")
	`ASSERT_SAME(a_blank_seg, load_out && !dec.lit, dec.segments == '0,
		"blank digit carries lit segments")

endmodule

FILE: tb/sv/seven_segment_scan_driver_core_tb.sv
// Self-checking testbench for the seven-segment scan driver core.
`timescale 1ns / 1ps

module seven_segment_scan_driver_core_tb;

	localparam int DIGITS = 4;
	localparam int unsigned TOP_VALUE = 9999;	// largest value that fits on four digits
	localparam int RANDOM_TICKS = 1900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ERR_SHOWN = 10;

	typedef logic [sssd_pkg::DigitPosW-1:0] pos_t;

	// One refresh tick as sent, plus an optional hand-written expectation.
	typedef struct {
		sssd_pkg::value_t value;
		logic             flag;
		logic             typed;
		pos_t             pos;
		sssd_pkg::seg_t   seg;
	} tick_t;

	// One displayed digit as it leaves the block.
	typedef struct {
		pos_t           pos;
		sssd_pkg::seg_t seg;
	} shown_t;

	// Segment patterns of the decimal digits, bit 0 top up to bit 6 middle.
	localparam sssd_pkg::seg_t GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	// Decimal weight of each scan position; position 0 is the leftmost digit.
	localparam int unsigned WEIGHT [DIGITS] = '{1000, 100, 10, 1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;	// [13:0] value_cm, [15:14] zero
	logic [0:0]  s_tuser = '0;	// [0] out_of_range
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;		// [1:0] digit_position, [8:2] segments, [15:9] zero

	seven_segment_scan_driver_core #(
		.DIGIT_COUNT(DIGITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	tick_t  ticks [$];
	shown_t display_q [$];

	// Predictor state: the position scanned next and the last position that lit.
	pos_t scan_pos;
	pos_t held_pos;

	int  cycles = 0;
	int  errors = 0;
	int  taken = 0;
	int  compared = 0;
	int  blanks = 0;
	logic steady = 1'b0;	// when set, neither side idles

	// Works out what one tick shows and advances the scan.
	function automatic shown_t decode_tick(input sssd_pkg::value_t value, input logic flag);
		shown_t r;
		int unsigned w;
		w = WEIGHT[scan_pos];
		r.seg = '0;
		if (!flag && value <= TOP_VALUE && (scan_pos == DIGITS - 1 || value >= w)) begin
			r.seg = GLYPH[(value / w) % 10];
			held_pos = scan_pos;
		end
		r.pos = held_pos;
		scan_pos = (scan_pos == 0) ? pos_t'(DIGITS - 1) : scan_pos - 1'b1;
		return r;
	endfunction

	// Random tick: mostly displayable values of every length, some too large, some flagged.
	function automatic tick_t random_tick();
		tick_t t;
		int unsigned len;
		int unsigned lo;
		t.typed = 1'b0;
		t.pos = '0;
		t.seg = '0;
		if ($urandom_range(99) < 10) begin
			t.value = sssd_pkg::value_t'($urandom_range(16383, 10000));
		end else begin
			len = $urandom_range(4, 1);
			lo = (len == 1) ? 0 : 10 ** (len - 1);
			t.value = sssd_pkg::value_t'($urandom_range(10 ** len - 1, lo));
		end
		t.flag = ($urandom_range(99) < 10);
		return t;
	endfunction

	// Directed rows start right after reset, scan at the rightmost digit. Rows with typed
	// set carry an expectation read straight off the rules; the rest use the predictor.
	initial begin
		ticks.push_back('{14'd0,     1'b0, 1'b1, 2'd3, 7'h3F});	// zero lights the rightmost 0
		ticks.push_back('{14'd0,     1'b0, 1'b1, 2'd3, 7'h00});	// leading position blank
		ticks.push_back('{14'd9999,  1'b0, 1'b1, 2'd1, 7'h6F});
		ticks.push_back('{14'd9999,  1'b0, 1'b1, 2'd0, 7'h6F});	// largest value shown
		ticks.push_back('{14'd10000, 1'b0, 1'b1, 2'd0, 7'h00});	// too large blanks
		ticks.push_back('{14'd16383, 1'b0, 1'b1, 2'd0, 7'h00});	// full-scale input
		ticks.push_back('{14'd1234,  1'b1, 1'b1, 2'd0, 7'h00});	// flag blanks
		ticks.push_back('{14'd1234,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd1234,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd1234,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd1234,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd5,     1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd5,     1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd56,    1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd567,   1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd9999,  1'b1, 1'b1, 2'd1, 7'h00});	// flag on a displayable value
		ticks.push_back('{14'd8076,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd8076,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd8076,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd8076,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd16383, 1'b1, 1'b1, 2'd0, 7'h00});	// both blanking causes at once
		ticks.push_back('{14'd10000, 1'b0, 1'b1, 2'd0, 7'h00});
		ticks.push_back('{14'd1000,  1'b0, 1'b0, 2'd0, 7'h00});
		ticks.push_back('{14'd999,   1'b0, 1'b0, 2'd0, 7'h00});	// just short of four digits
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			ticks.push_back(random_tick());
		end
	end

	// Sender: holds each tick until the block takes it, idling now and then between ticks.
	initial begin
		int i;
		i = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (i = 0; i < ticks.size(); i++) begin
			// A long run in the middle goes with no gaps on either side.
			steady <= (i >= 700 && i < 1000);
			while (!steady && $urandom_range(99) < 20) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {2'b00, ticks[i].value};
			s_tuser <= ticks[i].flag;
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;

		while (display_q.size() != 0) @(posedge clk);
		// Two-stage pipeline: running on after the queue drains shows up any stray result.
		repeat (8) @(posedge clk);

		$display("%0d ticks sent, %0d digits compared, %0d of them blank, %0d still due",
			taken, compared, blanks, display_q.size());
		if (errors == 0 && display_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Receiver: stalls about one cycle in five, except during the steady run.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 20);
	end

	// Both handshakes are observed here so the result check always sees the queue
	// before the same edge adds to it.
	always @(posedge clk) begin
		shown_t got;
		shown_t want;
		shown_t calc;
		if (!arst_n) begin
			scan_pos = pos_t'(DIGITS - 1);
			held_pos = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.pos = m_tdata[1:0];
				got.seg = m_tdata[8:2];
				if (display_q.size() == 0) begin
					errors++;
					if (errors <= ERR_SHOWN)
						$display("unexpected result: pos %0d seg %h", got.pos, got.seg);
				end else begin
					want = display_q.pop_front();
					compared++;
					if (want.seg == '0)
						blanks++;
					if (got.pos !== want.pos || got.seg !== want.seg) begin
						errors++;
						if (errors <= ERR_SHOWN)
							$display("result %0d: expected pos %0d seg %h, got pos %0d seg %h",
								compared, want.pos, want.seg, got.pos, got.seg);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				calc = decode_tick(s_tdata[13:0], s_tuser[0]);
				if (ticks[taken].typed) begin
					calc.pos = ticks[taken].pos;
					calc.seg = ticks[taken].seg;
				end
				display_q.push_back(calc);
				taken++;
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
